>>> rtl/c3s_pkg.sv
// Shared types and constants for the 3x3 Cramer solver.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package c3s_pkg;

    localparam int IN_W    = 16;  // Q8.8 entry width
    localparam int OUT_W   = 32;  // Q16.16 result width
    localparam int THR_W   = 48;  // threshold register width
    localparam int DET_W   = 50;  // signed determinant width
    localparam int MAG_W   = 49;  // determinant magnitude width
    localparam int QUO_W   = 33;  // unsaturated quotient bits
    localparam int FRAC_SH = 16;  // Q16.16 scaling of the numerator
    localparam int DET_LAT = 3;
    localparam int DIV_LAT = QUO_W + 2;
    localparam int LAT     = DET_LAT + DIV_LAT + 1;

    typedef logic signed [IN_W-1:0]  q88_t;
    typedef q88_t                    mat_t [9];
    typedef logic signed [DET_W-1:0] det_t;
    typedef logic signed [OUT_W-1:0] q1616_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SINGULAR = 2'd1,
        ST_SAT      = 2'd2
    } status_t;

    typedef struct packed {
        q1616_t q;
        logic   sat;
    } div_res_t;

endpackage

`default_nettype wire

>>> rtl/cramer_3x3_solver_unit.sv
// Pipeline: 3 determinant stages, then 35 divider stages including entry and
// clamp, then 1 output register.
// Throughput: one transaction per cycle; the whole pipeline holds while a
// result waits at the output, so a stall loses and repeats nothing.
// Reset (rst_n, async, active low): all valid bits clear, det_threshold = 1.
// Depends on c3s_pkg, c3s_det3, c3s_div.
`default_nettype none

module cramer_3x3_solver_unit
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_wr_en,
    input  wire logic [47:0]  cfg_wr_data,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic signed [15:0] a00,
    input  wire logic signed [15:0] a01,
    input  wire logic signed [15:0] a02,
    input  wire logic signed [15:0] a10,
    input  wire logic signed [15:0] a11,
    input  wire logic signed [15:0] a12,
    input  wire logic signed [15:0] a20,
    input  wire logic signed [15:0] a21,
    input  wire logic signed [15:0] a22,
    input  wire logic signed [15:0] b0,
    input  wire logic signed [15:0] b1,
    input  wire logic signed [15:0] b2,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic signed [31:0] x0,
    output logic signed [31:0] x1,
    output logic signed [31:0] x2,
    output logic [1:0]        status
);

    localparam int LAT = c3s_pkg::LAT;
    localparam int DL  = c3s_pkg::DIV_LAT;

    logic                        en;
    logic [c3s_pkg::THR_W-1:0]   thr_reg;
    logic [LAT-1:0]              vld_reg;
    logic [DL-1:0]               sing_reg;
    c3s_pkg::mat_t               ma;
    c3s_pkg::mat_t               mx [3];
    c3s_pkg::det_t               det_a;
    c3s_pkg::det_t               det_x [3];
    c3s_pkg::det_t               det_abs;
    logic                        sing_next;
    c3s_pkg::div_res_t           dres [3];
    c3s_pkg::q1616_t             x_reg [3];
    c3s_pkg::status_t            status_reg;

    // Advance everything together unless a result is held at the output.
    assign en       = !vld_reg[LAT-1] || out_ready;
    assign in_ready = en;

    assign ma = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};
    // column i replaced by b
    assign mx[0] = '{b0, a01, a02, b1, a11, a12, b2, a21, a22};
    assign mx[1] = '{a00, b0, a02, a10, b1, a12, a20, b2, a22};
    assign mx[2] = '{a00, a01, b0, a10, a11, b1, a20, a21, b2};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= c3s_pkg::THR_W'(1);
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    c3s_det3 u_det_a
    (
        .clk (clk),
        .en  (en),
        .m   (ma),
        .det (det_a)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_col
        c3s_det3 u_det_x
        (
            .clk (clk),
            .en  (en),
            .m   (mx[i]),
            .det (det_x[i])
        );

        c3s_div u_div
        (
            .clk (clk),
            .en  (en),
            .n   (det_x[i]),
            .d   (det_a),
            .res (dres[i])
        );
    end

    // Singular test runs beside the divider entry stage, then rides along.
    assign det_abs   = (det_a < 0) ? -det_a : det_a;
    assign sing_next = (det_a == '0) ||
                       (det_abs[c3s_pkg::MAG_W-1:0] < {1'b0, thr_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sing_reg <= {sing_reg[DL-2:0], sing_next};
        end
    end

    // Output register: drop quotients of a singular system, merge status.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (sing_reg[DL-1])
            begin
                x_reg[0]   <= '0;
                x_reg[1]   <= '0;
                x_reg[2]   <= '0;
                status_reg <= c3s_pkg::ST_SINGULAR;
            end
            else
            begin
                x_reg[0]   <= dres[0].q;
                x_reg[1]   <= dres[1].q;
                x_reg[2]   <= dres[2].q;
                status_reg <= (dres[0].sat || dres[1].sat || dres[2].sat) ?
                              c3s_pkg::ST_SAT : c3s_pkg::ST_OK;
            end
        end
    end

    assign out_valid = vld_reg[LAT-1];
    assign x0        = x_reg[0];
    assign x1        = x_reg[1];
    assign x2        = x_reg[2];
    assign status    = status_reg;

endmodule

`default_nettype wire

>>> rtl/c3s_det3.sv
// Three-stage pipelined 3x3 determinant by cofactor expansion on row 0.
// Depends on c3s_pkg.
`default_nettype none

module c3s_det3
(
    input  wire logic          clk,
    input  wire logic          en,
    input  wire c3s_pkg::mat_t m,
    output c3s_pkg::det_t      det
);

    logic signed [31:0] p_reg [6];
    c3s_pkg::q88_t      r0_reg [3];
    logic signed [32:0] diff [3];
    logic signed [48:0] t_reg [3];
    c3s_pkg::det_t      det_reg;

    assign diff[0] = 33'(p_reg[0]) - 33'(p_reg[1]);
    assign diff[1] = 33'(p_reg[2]) - 33'(p_reg[3]);
    assign diff[2] = 33'(p_reg[4]) - 33'(p_reg[5]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // products of the 2x2 minors
            p_reg[0]  <= m[4] * m[8];
            p_reg[1]  <= m[5] * m[7];
            p_reg[2]  <= m[3] * m[8];
            p_reg[3]  <= m[5] * m[6];
            p_reg[4]  <= m[3] * m[7];
            p_reg[5]  <= m[4] * m[6];
            r0_reg[0] <= m[0];
            r0_reg[1] <= m[1];
            r0_reg[2] <= m[2];
            // weight each minor by its row-0 entry
            t_reg[0]  <= r0_reg[0] * diff[0];
            t_reg[1]  <= r0_reg[1] * diff[1];
            t_reg[2]  <= r0_reg[2] * diff[2];
            det_reg   <= c3s_pkg::DET_W'(t_reg[0]) - c3s_pkg::DET_W'(t_reg[1])
                       + c3s_pkg::DET_W'(t_reg[2]);
        end
    end

    assign det = det_reg;

endmodule

`default_nettype wire

>>> rtl/c3s_div.sv
// Pipelined signed Q16.16 divider, one restoring step per stage, saturating.
// Depends on c3s_pkg.
`default_nettype none

module c3s_div
(
    input  wire logic           clk,
    input  wire logic           en,
    input  wire c3s_pkg::det_t  n,
    input  wire c3s_pkg::det_t  d,
    output c3s_pkg::div_res_t   res
);

    localparam int QW = c3s_pkg::QUO_W;
    localparam int MW = c3s_pkg::MAG_W;
    localparam int RW = MW + 1;
    localparam int SH = QW - c3s_pkg::FRAC_SH;

    c3s_pkg::det_t     n_abs;
    c3s_pkg::det_t     d_abs;
    logic [RW-1:0]     rem_reg  [QW+1];
    logic [QW-1:0]     bits_reg [QW+1];
    logic [QW-1:0]     quo_reg  [QW+1];
    logic [MW-1:0]     dm_reg   [QW+1];
    logic              neg_reg  [QW+1];
    logic              ovf_reg  [QW+1];
    c3s_pkg::div_res_t res_reg;
    c3s_pkg::div_res_t res_next;

    assign n_abs = (n < 0) ? -n : n;
    assign d_abs = (d < 0) ? -d : d;

    // entry stage: magnitudes, sign and the coarse overflow test
    // (the quotient needs more than QW bits when the top numerator bits reach d)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= RW'(n_abs[MW-1:SH]);
            bits_reg[0] <= {n_abs[SH-1:0], {c3s_pkg::FRAC_SH{1'b0}}};
            quo_reg[0]  <= '0;
            dm_reg[0]   <= d_abs[MW-1:0];
            neg_reg[0]  <= (n < 0) != (d < 0);
            ovf_reg[0]  <= MW'(n_abs[MW-1:SH]) >= d_abs[MW-1:0];
        end
    end

    for (genvar s = 0; s < QW; s++)
    begin : g_step
        logic [RW-1:0] trial;
        logic          ge;

        assign trial = {rem_reg[s][RW-2:0], bits_reg[s][QW-1]};
        assign ge    = trial >= {1'b0, dm_reg[s]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1]  <= ge ? trial - {1'b0, dm_reg[s]} : trial;
                bits_reg[s+1] <= bits_reg[s] << 1;
                quo_reg[s+1]  <= {quo_reg[s][QW-2:0], ge};
                dm_reg[s+1]   <= dm_reg[s];
                neg_reg[s+1]  <= neg_reg[s];
                ovf_reg[s+1]  <= ovf_reg[s];
            end
        end
    end

    // apply sign and clamp to the Q16.16 range
    always_comb
    begin
        res_next.sat = 1'b0;
        res_next.q   = '0;
        if (neg_reg[QW])
        begin
            if (ovf_reg[QW] || quo_reg[QW] > QW'(33'h0_8000_0000))
            begin
                res_next.sat = 1'b1;
                res_next.q   = 32'sh8000_0000;
            end
            else
            begin
                res_next.q = -c3s_pkg::q1616_t'(quo_reg[QW][c3s_pkg::OUT_W-1:0]);
            end
        end
        else
        begin
            if (ovf_reg[QW] || quo_reg[QW] > QW'(33'h0_7FFF_FFFF))
            begin
                res_next.sat = 1'b1;
                res_next.q   = 32'sh7FFF_FFFF;
            end
            else
            begin
                res_next.q = c3s_pkg::q1616_t'(quo_reg[QW][c3s_pkg::OUT_W-1:0]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

>>> rtl/c3s_checker.sv
// Port-level assertions for cramer_3x3_solver_unit, bound to the top level.
// Depends on c3s_pkg.
`default_nettype none

module c3s_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] x0,
    input wire logic [31:0] x1,
    input wire logic [31:0] x2,
    input wire logic [1:0]  status
);

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == c3s_pkg::ST_OK || status == c3s_pkg::ST_SINGULAR
                       || status == c3s_pkg::ST_SAT))
        else $error("status code out of range");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == c3s_pkg::ST_SINGULAR) |-> (x0 == '0 && x1 == '0 && x2 == '0))
        else $error("singular transaction with nonzero solution");

    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready disagrees with output hold");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(x0) && $stable(x1)
                                       && $stable(x2) && $stable(status)))
        else $error("held result changed");

endmodule

bind cramer_3x3_solver_unit c3s_checker u_c3s_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .x0        (x0),
    .x1        (x1),
    .x2        (x2),
    .status    (status)
);

`default_nettype wire

>>> tb/cramer_3x3_solver_unit_tb.sv
// Self-checking testbench for cramer_3x3_solver_unit: a directed table, then random
// matrices, each result compared field by field against an in-bench Cramer solver.
// Depends on c3s_pkg and the RTL of the solver unit.
`timescale 1ns / 1ps

module cramer_3x3_solver_unit_tb;

    localparam int RAND_ITEMS = 1250;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = c3s_pkg::LAT + 20;

    typedef struct {
        logic signed [15:0] m [12]; // a00..a22, b0..b2
    } system_t;

    typedef struct {
        logic signed [31:0] x [3];
        c3s_pkg::status_t   st;
    } solution_t;

    // One row of the directed table; has_sol marks a hand-typed answer.
    typedef struct {
        system_t   sys;
        bit        has_sol;
        solution_t sol;
    } vec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [47:0] cfg_wr_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] a_in [12];
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] x0, x1, x2;
    logic [1:0] status;

    logic [47:0] det_limit;     // local copy of the threshold register
    solution_t   pending_sols [$];
    bit          failed = 1'b0;
    bit          stall_enable = 1'b1;
    int          idle_cycles = 0;
    int          out_hold = 0;

    initial
    begin
        for (int i = 0; i < 12; i++)
            a_in[i] = '0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    cramer_3x3_solver_unit DUT
    (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .a00(a_in[0]), .a01(a_in[1]), .a02(a_in[2]),
        .a10(a_in[3]), .a11(a_in[4]), .a12(a_in[5]),
        .a20(a_in[6]), .a21(a_in[7]), .a22(a_in[8]),
        .b0(a_in[9]), .b1(a_in[10]), .b2(a_in[11]),
        .out_valid(out_valid), .out_ready(out_ready),
        .x0(x0), .x1(x1), .x2(x2), .status(status)
    );

    // Determinant of a 3x3 with entries widened to 64 bits; exact for Q8.8 inputs.
    function automatic longint det_of(longint e [9]);
        return e[0] * (e[4] * e[8] - e[5] * e[7])
             - e[1] * (e[3] * e[8] - e[5] * e[6])
             + e[2] * (e[3] * e[7] - e[4] * e[6]);
    endfunction

    function automatic solution_t solve_system(system_t s);
        solution_t r;
        longint a [9];
        longint m [9];
        longint d, n;
        logic [63:0] dm, nm, q;
        bit neg, sat;
        sat = 1'b0;
        for (int i = 0; i < 9; i++)
            a[i] = s.m[i];
        d = det_of(a);
        dm = (d < 0) ? -d : d;
        if (d == 0 || dm < {16'd0, det_limit})
        begin
            r.x[0] = 0; r.x[1] = 0; r.x[2] = 0;
            r.st = c3s_pkg::ST_SINGULAR;
            return r;
        end
        for (int c = 0; c < 3; c++)
        begin
            // Replace column c with the right-hand side.
            for (int k = 0; k < 9; k++)
                m[k] = ((k % 3) == c) ? longint'(s.m[9 + k / 3]) : a[k];
            n = det_of(m);
            nm = (n < 0) ? -n : n;
            q = (nm << 16) / dm;
            neg = (n < 0) != (d < 0);
            if (neg)
            begin
                if (q > 64'h8000_0000)
                begin
                    sat = 1'b1;
                    q = 64'h8000_0000;
                end
                r.x[c] = -q[31:0];
            end
            else if (q > 64'h7FFF_FFFF)
            begin
                sat = 1'b1;
                r.x[c] = 32'h7FFF_FFFF;
            end
            else
                r.x[c] = q[31:0];
        end
        r.st = sat ? c3s_pkg::ST_SAT : c3s_pkg::ST_OK;
        return r;
    endfunction

    // Output side: backpressure in bursts and the scoreboard compare.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_hold  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_sols.size() == 0)
                begin
                    $error("unexpected result x0=%0d x1=%0d x2=%0d status=%0d",
                           x0, x1, x2, status);
                    failed = 1'b1;
                end
                else
                begin
                    solution_t e;
                    e = pending_sols.pop_front();
                    if (x0 !== e.x[0])
                    begin
                        $error("x0 expected %0d actual %0d", e.x[0], x0);
                        failed = 1'b1;
                    end
                    if (x1 !== e.x[1])
                    begin
                        $error("x1 expected %0d actual %0d", e.x[1], x1);
                        failed = 1'b1;
                    end
                    if (x2 !== e.x[2])
                    begin
                        $error("x2 expected %0d actual %0d", e.x[2], x2);
                        failed = 1'b1;
                    end
                    if (status !== e.st)
                    begin
                        $error("status expected %0d actual %0d", e.st, status);
                        failed = 1'b1;
                    end
                end
            end
            if (stall_enable && out_hold > 0)
            begin
                out_hold  <= out_hold - 1;
                out_ready <= 1'b0;
            end
            else if (stall_enable && $urandom_range(0, 7) == 0)
            begin
                out_hold  <= $urandom_range(0, 10);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog: count cycles with no transaction on either side.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Present one system; hold it until the handshake takes it. Valid stays
    // high between back-to-back transactions and drops only for idle bursts and drains.
    task automatic send_system(system_t s, bit check_table, solution_t sol);
        solution_t p;
        if (stall_enable && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        p = solve_system(s);
        if (check_table && (p.x[0] !== sol.x[0] || p.x[1] !== sol.x[1]
                            || p.x[2] !== sol.x[2] || p.st !== sol.st))
        begin
            $error("table row disagrees with solver: status %0d vs %0d", sol.st, p.st);
            failed = 1'b1;
        end
        for (int i = 0; i < 12; i++)
            a_in[i] <= s.m[i];
        in_valid <= 1'b1;
        pending_sols.push_back(check_table ? sol : p);
        do @(posedge clk); while (!in_ready);
    endtask

    // Drop valid, wait for all results, then let the pipe empty before a register write.
    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (pending_sols.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(logic [47:0] v);
        drain_pipe();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        det_limit = v;
    endtask

    function automatic system_t diag_system(int d, int bv);
        system_t s;
        for (int i = 0; i < 12; i++)
            s.m[i] = '0;
        s.m[0] = 16'(d); s.m[4] = 16'(d); s.m[8] = 16'(d);
        s.m[9] = 16'(bv); s.m[10] = 16'(bv); s.m[11] = 16'(bv);
        return s;
    endfunction

    // Random system: mostly small, well-conditioned values; sometimes full range
    // or a deliberately dependent row to make it singular.
    function automatic system_t random_system();
        system_t s;
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 12; i++)
        begin
            if (kind < 4)
                s.m[i] = 16'($urandom);
            else
                s.m[i] = 16'($signed($urandom_range(0, 2047)) - 1024);
        end
        if (kind == 9)
            for (int c = 0; c < 3; c++)
                s.m[6 + c] = s.m[c];
        else if (kind >= 6)
            for (int i = 0; i < 3; i++)
                s.m[i * 4] = s.m[i * 4] + ((($urandom & 1) != 0) ? 16'sd4096 : -16'sd4096);
        return s;
    endfunction

    function automatic vec_t row(system_t s, bit typed, int v0, int v1, int v2,
                                 c3s_pkg::status_t st);
        vec_t r;
        r.sys = s;
        r.has_sol = typed;
        r.sol.x[0] = v0; r.sol.x[1] = v1; r.sol.x[2] = v2;
        r.sol.st = st;
        return r;
    endfunction

    initial
    begin
        vec_t table_rows [$];
        system_t s;
        int phase_items;

        det_limit = 48'd1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: identity, zero matrix, quotient range limits, extremes.
        table_rows.push_back(row(diag_system(256, 256), 1, 65536, 65536, 65536,
                                 c3s_pkg::ST_OK));
        table_rows.push_back(row(diag_system(256, -256), 1, -65536, -65536, -65536,
                                 c3s_pkg::ST_OK));
        table_rows.push_back(row(diag_system(0, 256), 1, 0, 0, 0, c3s_pkg::ST_SINGULAR));
        // Largest quotient of a positive-determinant diagonal system, just under the limit.
        table_rows.push_back(row(diag_system(1, 32767), 1, 32'h7FFF_0000, 32'h7FFF_0000,
                                 32'h7FFF_0000, c3s_pkg::ST_OK));
        // Exactly -2^31: not an overflow.
        table_rows.push_back(row(diag_system(1, -32768), 1, 32'h8000_0000, 32'h8000_0000,
                                 32'h8000_0000, c3s_pkg::ST_OK));
        // b = -128.0 over a = 1.0 in Q8.8.
        table_rows.push_back(row(diag_system(256, -32768), 1, -8388608, -8388608,
                                 -8388608, c3s_pkg::ST_OK));
        table_rows.push_back(row(diag_system(-32768, 32767), 0, 0, 0, 0, c3s_pkg::ST_OK));
        table_rows.push_back(row(diag_system(32767, -32768), 0, 0, 0, 0, c3s_pkg::ST_OK));
        table_rows.push_back(row(diag_system(-1, -1), 0, 0, 0, 0, c3s_pkg::ST_OK));
        for (int i = 0; i < 12; i++)
            s.m[i] = -16'sd32768;
        table_rows.push_back(row(s, 1, 0, 0, 0, c3s_pkg::ST_SINGULAR));
        for (int i = 0; i < 12; i++)
            s.m[i] = 16'sd32767;
        table_rows.push_back(row(s, 1, 0, 0, 0, c3s_pkg::ST_SINGULAR));
        for (int k = 0; k < 8; k++)
            table_rows.push_back(row(random_system(), 0, 0, 0, 0, c3s_pkg::ST_OK));

        foreach (table_rows[i])
            send_system(table_rows[i].sys, table_rows[i].has_sol, table_rows[i].sol);

        // Random phases over several threshold settings, extremes included.
        // Writing each one drains the pipe first, so the sender pauses here.
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: write_limit(48'd0);
                1: write_limit(48'hFFFF_FFFF_FFFF);
                2: write_limit({16'd0, $urandom} << $urandom_range(0, 16));
                3: write_limit(48'd1 << 36);
                default: write_limit(48'd1);
            endcase
            phase_items = (ph == 1) ? 40 : 300;
            if (ph == 4)
                stall_enable = 1'b0;    // final stretch runs with no idling
            for (int k = 0; k < phase_items; k++)
            begin
                s = random_system();
                send_system(s, 1'b0, solve_system(s));
            end
        end

        drain_pipe();
        if (!failed)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> cramer_3x3_solver_unit.f
rtl/c3s_pkg.sv
rtl/c3s_det3.sv
rtl/c3s_div.sv
rtl/cramer_3x3_solver_unit.sv
rtl/c3s_checker.sv
tb/cramer_3x3_solver_unit_tb.sv
